// ===== design/assert_macros.svh =====
// Assertion macros for the port checker of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, reset included.
`define KEQKM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Check a property on every rising clock edge outside reset.
`define KEQKM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== design/keqkm_pkg.sv =====
// Types, constants and key map table for the key event queue and keyboard matrix.
package keqkm_pkg;

  localparam int QUEUE_DEPTH_DEF = 512;

  localparam int CODE_W  = 9;
  localparam int EVENT_W = CODE_W + 1;
  localparam int COUNT_W = 10;
  localparam int IN_DW   = 16;
  localparam int OUT_DW  = 144;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POLL = 1'b1;

  localparam logic [2:0] SHIFT_ROW = 3'd6;
  localparam logic [2:0] SHIFT_BIT = 3'd4;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_FETCH
  } state_t;

  typedef struct packed {
    logic       mapped;
    logic       force_shift;
    logic [2:0] row;
    logic [2:0] col;
  } key_map_t;

  function automatic key_map_t key_at(logic [2:0] r, logic [2:0] b, logic fs);
    key_map_t m;
    m.mapped      = 1'b1;
    m.force_shift = fs;
    m.row         = r;
    m.col         = b;
    return m;
  endfunction

  function automatic key_map_t key_lookup(logic [CODE_W-1:0] code);
    key_map_t m;
    m = '0;
    case (code)
      9'd97:  m = key_at(3'd1, 3'd2, 1'b0);
      9'd98:  m = key_at(3'd3, 3'd4, 1'b0);
      9'd99:  m = key_at(3'd2, 3'd4, 1'b0);
      9'd100: m = key_at(3'd2, 3'd2, 1'b0);
      9'd101: m = key_at(3'd1, 3'd6, 1'b0);
      9'd102: m = key_at(3'd2, 3'd5, 1'b0);
      9'd103: m = key_at(3'd3, 3'd2, 1'b0);
      9'd104: m = key_at(3'd3, 3'd5, 1'b0);
      9'd105: m = key_at(3'd4, 3'd1, 1'b0);
      9'd106: m = key_at(3'd4, 3'd2, 1'b0);
      9'd107: m = key_at(3'd4, 3'd5, 1'b0);
      9'd108: m = key_at(3'd5, 3'd2, 1'b0);
      9'd109: m = key_at(3'd4, 3'd4, 1'b0);
      9'd110: m = key_at(3'd4, 3'd7, 1'b0);
      9'd111: m = key_at(3'd4, 3'd6, 1'b0);
      9'd112: m = key_at(3'd5, 3'd1, 1'b0);
      9'd113: m = key_at(3'd7, 3'd6, 1'b0);
      9'd114: m = key_at(3'd2, 3'd1, 1'b0);
      9'd115: m = key_at(3'd1, 3'd5, 1'b0);
      9'd116: m = key_at(3'd2, 3'd6, 1'b0);
      9'd117: m = key_at(3'd3, 3'd6, 1'b0);
      9'd118: m = key_at(3'd3, 3'd7, 1'b0);
      9'd119: m = key_at(3'd1, 3'd1, 1'b0);
      9'd120: m = key_at(3'd2, 3'd7, 1'b0);
      9'd121: m = key_at(3'd3, 3'd1, 1'b0);
      9'd122: m = key_at(3'd1, 3'd4, 1'b0);
      9'd48:  m = key_at(3'd4, 3'd3, 1'b0);
      9'd49:  m = key_at(3'd7, 3'd0, 1'b0);
      9'd50:  m = key_at(3'd7, 3'd3, 1'b0);
      9'd51:  m = key_at(3'd1, 3'd0, 1'b0);
      9'd52:  m = key_at(3'd1, 3'd3, 1'b0);
      9'd53:  m = key_at(3'd2, 3'd0, 1'b0);
      9'd54:  m = key_at(3'd2, 3'd3, 1'b0);
      9'd55:  m = key_at(3'd3, 3'd0, 1'b0);
      9'd56:  m = key_at(3'd3, 3'd3, 1'b0);
      9'd57:  m = key_at(3'd4, 3'd0, 1'b0);
      9'd32:  m = key_at(3'd7, 3'd4, 1'b0);
      9'd96:  m = key_at(3'd7, 3'd1, 1'b0);
      9'd92:  m = key_at(3'd6, 3'd6, 1'b0);
      9'd44:  m = key_at(3'd5, 3'd7, 1'b0);
      9'd46:  m = key_at(3'd5, 3'd4, 1'b0);
      9'd45:  m = key_at(3'd5, 3'd0, 1'b0);
      9'd61:  m = key_at(3'd6, 3'd5, 1'b0);
      9'd91:  m = key_at(3'd5, 3'd6, 1'b0);
      9'd93:  m = key_at(3'd6, 3'd1, 1'b0);
      9'd59:  m = key_at(3'd5, 3'd5, 1'b0);
      9'd39:  m = key_at(3'd6, 3'd2, 1'b0);
      9'd47:  m = key_at(3'd6, 3'd7, 1'b0);
      9'd63:  m = key_at(3'd6, 3'd7, 1'b1);
      9'd34:  m = key_at(3'd7, 3'd3, 1'b1);
      9'd36:  m = key_at(3'd1, 3'd3, 1'b1);
      9'd27:  m = key_at(3'd7, 3'd7, 1'b0);
      9'd13:  m = key_at(3'd0, 3'd1, 1'b0);
      9'd8:   m = key_at(3'd0, 3'd0, 1'b0);
      9'd127: m = key_at(3'd0, 3'd0, 1'b0);
      9'd277: m = key_at(3'd6, 3'd3, 1'b0);
      9'd278: m = key_at(3'd6, 3'd3, 1'b0);
      9'd279: m = key_at(3'd6, 3'd0, 1'b0);
      9'd280: m = key_at(3'd6, 3'd0, 1'b0);
      9'd281: m = key_at(3'd6, 3'd5, 1'b0);
      9'd306: m = key_at(3'd7, 3'd2, 1'b0);
      9'd9:   m = key_at(3'd7, 3'd2, 1'b0);
      9'd305: m = key_at(3'd7, 3'd5, 1'b0);
      9'd304: m = key_at(3'd1, 3'd7, 1'b0);
      9'd303: m = key_at(3'd6, 3'd4, 1'b0);
      9'd307: m = key_at(3'd7, 3'd5, 1'b0);
      9'd308: m = key_at(3'd7, 3'd5, 1'b0);
      9'd309: m = key_at(3'd7, 3'd5, 1'b0);
      9'd310: m = key_at(3'd7, 3'd5, 1'b0);
      9'd273: m = key_at(3'd0, 3'd7, 1'b1);
      9'd274: m = key_at(3'd0, 3'd7, 1'b0);
      9'd276: m = key_at(3'd0, 3'd2, 1'b1);
      9'd275: m = key_at(3'd0, 3'd2, 1'b0);
      9'd282: m = key_at(3'd0, 3'd4, 1'b0);
      9'd283: m = key_at(3'd0, 3'd4, 1'b1);
      9'd284: m = key_at(3'd0, 3'd5, 1'b0);
      9'd285: m = key_at(3'd0, 3'd5, 1'b1);
      9'd286: m = key_at(3'd0, 3'd6, 1'b0);
      9'd287: m = key_at(3'd0, 3'd6, 1'b1);
      9'd288: m = key_at(3'd0, 3'd3, 1'b0);
      9'd289: m = key_at(3'd0, 3'd3, 1'b1);
      9'd267: m = key_at(3'd6, 3'd7, 1'b0);
      9'd271: m = key_at(3'd0, 3'd1, 1'b0);
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ===== design/key_event_queue_to_keyboard_matrix_top.sv =====
// Key event ring queue in block memory driving an emulated 8x8 keyboard matrix.
//
//   group | dir | tdata fields (low bit up)                                 | tuser
//   in_   | in  | key_code[8:0], release_req[9], zero pad to 16             | func[0]
//   out_  | out | rows_out[63:0], columns_out[127:64], queued_count[137:128],|
//         |     | push_dropped[138], event_applied[139], zero pad to 144    | -
//
// A push or a poll on an empty queue gives its result in the cycle after acceptance.
// A poll on a non-empty queue loads its result after the registered read of the
// event memory. One transaction is in work at a time; a result waits in the output
// register while the next transaction is taken if that register is being emptied.
// Reset (synchronous, active low) empties the queue and releases every key; the
// event memory itself is not cleared. An output stall holds the block in place.
module key_event_queue_to_keyboard_matrix_top #(
  parameter int QUEUE_DEPTH = keqkm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [keqkm_pkg::IN_DW-1:0] in_tdata,   // key_code, release_req
  input  logic [0:0]                  in_tuser,   // func
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [keqkm_pkg::OUT_DW-1:0] out_tdata  // rows_out, columns_out,
                                                  // queued_count, push_dropped,
                                                  // event_applied
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int EV_W  = keqkm_pkg::EVENT_W;
  localparam int CW    = keqkm_pkg::CODE_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [EV_W-1:0] event_mem [QUEUE_DEPTH];
  logic [EV_W-1:0] mem_q_r;

  keqkm_pkg::state_t state_r, state_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [7:0][7:0]   rows_r, rows_nxt;
  logic [7:0][7:0]   cols_r, cols_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [keqkm_pkg::OUT_DW-1:0] out_data_r, out_data_nxt;

  logic              slot_free;
  logic              in_acc;
  logic              mem_we;
  logic              mem_re;
  logic              out_load;
  logic              dropped;
  logic              applied;
  logic              rel;
  keqkm_pkg::key_map_t km;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == keqkm_pkg::ST_IDLE) && slot_free;
  assign in_acc    = in_tvalid && in_tready;
  assign km        = keqkm_pkg::key_lookup(mem_q_r[CW-1:0]);
  assign rel       = mem_q_r[CW];

  always_comb begin
    state_nxt  = state_r;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    out_load   = 1'b0;
    dropped    = 1'b0;
    applied    = 1'b0;
    case (state_r)
      keqkm_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser[0] == keqkm_pkg::FUNC_PUSH) begin
            out_load = 1'b1;
            if (count_r < CNT_FULL) begin
              mem_we     = 1'b1;
              wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
              count_nxt  = count_r + 1'b1;
            end else begin
              dropped = 1'b1;
            end
          end else if (count_r != '0) begin
            mem_re     = 1'b1;
            rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
            count_nxt  = count_r - 1'b1;
            state_nxt  = keqkm_pkg::ST_FETCH;
          end else begin
            out_load = 1'b1;
          end
        end
      end
      keqkm_pkg::ST_FETCH: begin
        if (slot_free) begin
          applied   = km.mapped && (mem_q_r[CW-1:0] != '0);
          out_load  = 1'b1;
          state_nxt = keqkm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = keqkm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (applied) begin
      if (km.force_shift) begin
        rows_nxt[keqkm_pkg::SHIFT_ROW][keqkm_pkg::SHIFT_BIT] = rel;
        cols_nxt[keqkm_pkg::SHIFT_BIT][keqkm_pkg::SHIFT_ROW] = rel;
      end
      rows_nxt[km.row][km.col] = rel;
      cols_nxt[km.col][km.row] = rel;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {4'b0000, applied, dropped,
                       keqkm_pkg::COUNT_W'(count_nxt), cols_nxt, rows_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      event_mem[wr_ptr_r] <= {in_tdata[CW], in_tdata[CW-1:0]};
    end
    if (mem_re) begin
      mem_q_r <= event_mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= keqkm_pkg::ST_IDLE;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
      rows_r      <= '1;
      cols_r      <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      count_r     <= count_nxt;
      rows_r      <= rows_nxt;
      cols_r      <= cols_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== design/keqkm_checker.sv =====
// Port-level checker for the key event queue and keyboard matrix, with its bind.
`include "assert_macros.svh"

module keqkm_port_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [keqkm_pkg::OUT_DW-1:0]  out_tdata
);

  logic stalled;
  logic drop_and_apply;

  assign stalled        = out_tvalid && !out_tready;
  assign drop_and_apply = out_tdata[138] && out_tdata[139];

  `KEQKM_ASSERT(a_reset_empties_output, !rst_n |=> !out_tvalid, "result shown after reset")

  `KEQKM_ASSERT_RST(a_stall_holds, stalled |=> out_tvalid && $stable(out_tdata), "stall broken")

  `KEQKM_ASSERT_RST(a_no_take_in_stall, stalled |-> !in_tready, "input taken in stall")

  `KEQKM_ASSERT_RST(a_drop_apply_excl, out_tvalid |-> !drop_and_apply, "drop and apply both set")

endmodule

bind key_event_queue_to_keyboard_matrix_top keqkm_port_checker u_keqkm_port_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== test/keqkm_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts the queue and keyboard matrices and compares every result transaction.
module keqkm_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [keqkm_pkg::IN_DW-1:0]   in_tdata,
  input  logic [0:0]                    in_tuser,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [keqkm_pkg::OUT_DW-1:0]  out_tdata,
  output int                            fail_count,
  output int                            pending
);

  typedef struct packed {
    logic         applied;
    logic         dropped;
    logic [9:0]   queued;
    logic [63:0]  cols;
    logic [63:0]  rows;
  } matrix_result_t;

  typedef struct packed {
    logic       hit;
    logic       shift;
    logic [2:0] row;
    logic [2:0] col;
  } key_slot_t;

  logic [keqkm_pkg::EVENT_W-1:0] key_events[$];
  matrix_result_t                expected_results[$];
  logic [7:0]                    key_rows[8];
  logic [7:0]                    key_cols[8];
  int                            mismatches = 0;
  int                            waiting = 0;

  assign fail_count = mismatches;
  assign pending    = waiting;

  function automatic key_slot_t spot(int r, int c, int s);
    key_slot_t k;
    k.hit   = 1'b1;
    k.shift = (s != 0);
    k.row   = r[2:0];
    k.col   = c[2:0];
    return k;
  endfunction

  function automatic key_slot_t key_position(logic [keqkm_pkg::CODE_W-1:0] code);
    key_slot_t k;
    k = '0;
    case (code)
      9'd97:  k = spot(1, 2, 0);  9'd98:  k = spot(3, 4, 0);  9'd99:  k = spot(2, 4, 0);
      9'd100: k = spot(2, 2, 0);  9'd101: k = spot(1, 6, 0);  9'd102: k = spot(2, 5, 0);
      9'd103: k = spot(3, 2, 0);  9'd104: k = spot(3, 5, 0);  9'd105: k = spot(4, 1, 0);
      9'd106: k = spot(4, 2, 0);  9'd107: k = spot(4, 5, 0);  9'd108: k = spot(5, 2, 0);
      9'd109: k = spot(4, 4, 0);  9'd110: k = spot(4, 7, 0);  9'd111: k = spot(4, 6, 0);
      9'd112: k = spot(5, 1, 0);  9'd113: k = spot(7, 6, 0);  9'd114: k = spot(2, 1, 0);
      9'd115: k = spot(1, 5, 0);  9'd116: k = spot(2, 6, 0);  9'd117: k = spot(3, 6, 0);
      9'd118: k = spot(3, 7, 0);  9'd119: k = spot(1, 1, 0);  9'd120: k = spot(2, 7, 0);
      9'd121: k = spot(3, 1, 0);  9'd122: k = spot(1, 4, 0);
      9'd48:  k = spot(4, 3, 0);  9'd49:  k = spot(7, 0, 0);  9'd50:  k = spot(7, 3, 0);
      9'd51:  k = spot(1, 0, 0);  9'd52:  k = spot(1, 3, 0);  9'd53:  k = spot(2, 0, 0);
      9'd54:  k = spot(2, 3, 0);  9'd55:  k = spot(3, 0, 0);  9'd56:  k = spot(3, 3, 0);
      9'd57:  k = spot(4, 0, 0);
      9'd32:  k = spot(7, 4, 0);  9'd96:  k = spot(7, 1, 0);  9'd92:  k = spot(6, 6, 0);
      9'd44:  k = spot(5, 7, 0);  9'd46:  k = spot(5, 4, 0);  9'd45:  k = spot(5, 0, 0);
      9'd61:  k = spot(6, 5, 0);  9'd91:  k = spot(5, 6, 0);  9'd93:  k = spot(6, 1, 0);
      9'd59:  k = spot(5, 5, 0);  9'd39:  k = spot(6, 2, 0);  9'd47:  k = spot(6, 7, 0);
      9'd63:  k = spot(6, 7, 1);  9'd34:  k = spot(7, 3, 1);  9'd36:  k = spot(1, 3, 1);
      9'd27:  k = spot(7, 7, 0);  9'd13:  k = spot(0, 1, 0);
      9'd8, 9'd127:           k = spot(0, 0, 0);
      9'd277, 9'd278:         k = spot(6, 3, 0);
      9'd279, 9'd280:         k = spot(6, 0, 0);
      9'd281:                 k = spot(6, 5, 0);
      9'd306, 9'd9:           k = spot(7, 2, 0);
      9'd305:                 k = spot(7, 5, 0);
      9'd304:                 k = spot(1, 7, 0);
      9'd303:                 k = spot(6, 4, 0);
      9'd307, 9'd308, 9'd309, 9'd310: k = spot(7, 5, 0);
      9'd273: k = spot(0, 7, 1);  9'd274: k = spot(0, 7, 0);
      9'd276: k = spot(0, 2, 1);  9'd275: k = spot(0, 2, 0);
      9'd282: k = spot(0, 4, 0);  9'd283: k = spot(0, 4, 1);
      9'd284: k = spot(0, 5, 0);  9'd285: k = spot(0, 5, 1);
      9'd286: k = spot(0, 6, 0);  9'd287: k = spot(0, 6, 1);
      9'd288: k = spot(0, 3, 0);  9'd289: k = spot(0, 3, 1);
      9'd267: k = spot(6, 7, 0);  9'd271: k = spot(0, 1, 0);
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic void press_or_release(logic [2:0] row, logic [2:0] col, logic up);
    if (up) begin
      key_rows[row][col] = 1'b1;
      key_cols[col][row] = 1'b1;
    end else begin
      key_rows[row][col] = 1'b0;
      key_cols[col][row] = 1'b0;
    end
  endfunction

  function automatic matrix_result_t advance_keyboard(logic f,
                                                      logic [keqkm_pkg::CODE_W-1:0] code,
                                                      logic up);
    matrix_result_t r;
    logic [keqkm_pkg::EVENT_W-1:0] ev;
    key_slot_t k;
    r = '0;
    if (f == keqkm_pkg::FUNC_PUSH) begin
      if (key_events.size() < keqkm_pkg::QUEUE_DEPTH_DEF) key_events.push_back({up, code});
      else r.dropped = 1'b1;
    end else if (key_events.size() != 0) begin
      ev = key_events.pop_front();
      k = key_position(ev[keqkm_pkg::CODE_W-1:0]);
      if (k.hit) begin
        if (k.shift) begin
          press_or_release(keqkm_pkg::SHIFT_ROW, keqkm_pkg::SHIFT_BIT,
                           ev[keqkm_pkg::CODE_W]);
        end
        press_or_release(k.row, k.col, ev[keqkm_pkg::CODE_W]);
        r.applied = 1'b1;
      end
    end
    for (int i = 0; i < 8; i++) begin
      r.rows[8*i +: 8] = key_rows[i];
      r.cols[8*i +: 8] = key_cols[i];
    end
    r.queued = 10'(key_events.size());
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    matrix_result_t seen;
    matrix_result_t want;
    if (!rst_n) begin
      key_events.delete();
      expected_results.delete();
      for (int i = 0; i < 8; i++) begin
        key_rows[i] = 8'hff;
        key_cols[i] = 8'hff;
      end
    end else begin
      if (out_tvalid && out_tready) begin
        seen = out_tdata[$bits(matrix_result_t)-1:0];
        if (expected_results.size() == 0) begin
          if (mismatches < 10) $display("unexpected result transaction: %h", out_tdata);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_results.pop_front();
          if (seen.rows !== want.rows || seen.cols !== want.cols ||
              seen.queued !== want.queued || seen.dropped !== want.dropped ||
              seen.applied !== want.applied) begin
            if (mismatches < 10)
              $display({"mismatch at %0t: rows %h/%h cols %h/%h queued %0d/%0d ",
                        "dropped %b/%b applied %b/%b (exp/act)"},
                       $realtime, want.rows, seen.rows, want.cols, seen.cols,
                       want.queued, seen.queued, want.dropped, seen.dropped,
                       want.applied, seen.applied);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(advance_keyboard(in_tuser[0],
                                                    in_tdata[keqkm_pkg::CODE_W-1:0],
                                                    in_tdata[keqkm_pkg::CODE_W]));
    end
    waiting <= expected_results.size();
  end

endmodule

// ===== test/key_event_queue_to_keyboard_matrix_top_tb.sv =====
`timescale 1ns / 1ps
// Stimulus, clock, reset and verdict for the key event queue and keyboard matrix block.
module key_event_queue_to_keyboard_matrix_top_tb;

  localparam int STALL_LIMIT = 2000;
  localparam int TOTAL_ITEMS = 500;

  logic                         clk        = 1'b0;
  logic                         rst_n      = 1'b0;
  logic                         in_tvalid  = 1'b0;
  logic                         in_tready;
  logic [keqkm_pkg::IN_DW-1:0]  in_tdata   = '0;
  logic [0:0]                   in_tuser   = '0;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [keqkm_pkg::OUT_DW-1:0] out_tdata;
  logic                         calm       = 1'b0;
  int                           fail_count;
  int                           pending;
  int                           sent_items   = 0;
  int                           quiet_cycles = 0;

  key_event_queue_to_keyboard_matrix_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  keqkm_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= 36);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_event(input logic f, input logic [keqkm_pkg::CODE_W-1:0] code,
                            input logic up);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 36) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {{(keqkm_pkg::IN_DW - keqkm_pkg::EVENT_W){1'b0}}, up, code};
    in_tuser  = f;
    do @(posedge clk); while (!in_tready);
    sent_items++;
  endtask

  function automatic logic [keqkm_pkg::CODE_W-1:0] pick_code();
    logic [keqkm_pkg::CODE_W-1:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2: c = 9'($urandom_range(97, 122));
      3:       c = 9'($urandom_range(48, 57));
      4:       c = 9'($urandom_range(273, 289));
      5:       c = 9'($urandom_range(303, 310));
      6: begin
        case ($urandom_range(0, 11))
          0:       c = 9'd63;
          1:       c = 9'd34;
          2:       c = 9'd36;
          3:       c = 9'd32;
          4:       c = 9'd13;
          5:       c = 9'd8;
          6:       c = 9'd127;
          7:       c = 9'd9;
          8:       c = 9'd27;
          9:       c = 9'd267;
          10:      c = 9'd271;
          default: c = 9'($urandom_range(39, 47));
        endcase
      end
      7:       c = 9'($urandom_range(256, 265));
      8:       c = 9'($urandom_range(0, 511));
      default: c = '0;
    endcase
    return c;
  endfunction

  task automatic send_poll();
    send_event(keqkm_pkg::FUNC_POLL, 9'($urandom_range(0, 511)), 1'($urandom_range(0, 1)));
  endtask

  // press a handful of keys, release them in reverse order, then poll them all out
  task automatic type_keys();
    logic [keqkm_pkg::CODE_W-1:0] keys[4];
    int n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      keys[i] = pick_code();
      send_event(keqkm_pkg::FUNC_PUSH, keys[i], 1'b0);
      if ($urandom_range(0, 1)) send_poll();
    end
    for (int i = n - 1; i >= 0; i--) send_event(keqkm_pkg::FUNC_PUSH, keys[i], 1'b1);
    repeat (2 * n) send_poll();
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    send_event(keqkm_pkg::FUNC_POLL, 9'h1ff, 1'b1);
    send_event(keqkm_pkg::FUNC_PUSH, 9'd0, 1'b0);
    send_event(keqkm_pkg::FUNC_PUSH, 9'h1ff, 1'b1);
    send_event(keqkm_pkg::FUNC_PUSH, 9'd63, 1'b0);
    send_event(keqkm_pkg::FUNC_PUSH, 9'd303, 1'b0);
    send_event(keqkm_pkg::FUNC_PUSH, 9'd34, 1'b1);
    send_event(keqkm_pkg::FUNC_PUSH, 9'd36, 1'b0);
    send_event(keqkm_pkg::FUNC_PUSH, 9'd273, 1'b0);
    send_event(keqkm_pkg::FUNC_PUSH, 9'd8, 1'b0);
    send_event(keqkm_pkg::FUNC_PUSH, 9'd127, 1'b1);
    send_event(keqkm_pkg::FUNC_PUSH, 9'd265, 1'b0);
    send_event(keqkm_pkg::FUNC_PUSH, 9'd97, 1'b0);
    repeat (12) send_event(keqkm_pkg::FUNC_POLL, 9'd0, 1'b0);

    while (sent_items < TOTAL_ITEMS) begin
      calm = (sent_items >= 200) && (sent_items < 300);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: type_keys();
        6, 7: send_event(1'($urandom_range(0, 1)), 9'($urandom_range(0, 511)),
                         1'($urandom_range(0, 1)));
        8:    send_event(keqkm_pkg::FUNC_PUSH, pick_code(), 1'($urandom_range(0, 1)));
        default: repeat ($urandom_range(1, 3)) send_poll();
      endcase
    end
    calm = 1'b0;

    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
